// ----- rtl/core/m3ir_pkg.sv -----
// Package for the median-of-three distance framer.
// Types, register indexes, reset values and the median function; no dependencies.
package m3ir_pkg;

    localparam int unsigned CODE_W   = 12;
    localparam int unsigned DIST_W   = 20;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned CFG_W    = 20;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIV_STEPS = DIST_W;
    localparam int unsigned STEP_W   = 5;

    localparam logic [CODE_W-1:0] NEAR_RST   = 12'd494;
    localparam logic [DIST_W-1:0] SCALE_RST  = 20'd268130;
    localparam logic [CODE_W-1:0] OFFSET_RST = 12'd159;
    localparam logic [CODE_W-1:0] FAR_RST    = 12'd799;
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR   = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_OFFSET = 2'd2,
        CFG_FAR    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_REARM  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic shift;     // sample accepted: shift the history
        logic start;     // capture median and position, bump frame count
        logic clear;     // rearm: frame count back to zero
        logic prep;      // load divider or far distance
        logic step;      // one restoring division step
        logic load_out;  // move result into the output word
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic frame_full;
        logic far_sel;
        logic out_free;
    } t_status;

    function automatic logic [CODE_W-1:0] mid_of_three(
        input logic [CODE_W-1:0] a,
        input logic [CODE_W-1:0] b,
        input logic [CODE_W-1:0] c
    );
        logic [CODE_W-1:0] lo;
        logic [CODE_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            return lo;
        end else if (c >= hi) begin
            return hi;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/m3ir_ifs.sv -----
// Valid/ready channel interfaces for the distance framer.
// Depends on m3ir_pkg for field widths.
interface m3ir_in_if import m3ir_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CODE_W-1:0] adc_code;

    modport source (output valid, output req_type, output adc_code, input ready);
    modport sink   (input valid, input req_type, input adc_code, output ready);
endinterface

interface m3ir_out_if import m3ir_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_mm;
    logic [CODE_W-1:0] median_code;
    logic [IDX_W-1:0]  frame_index;
    logic              frame_last;

    modport source (output valid, output distance_mm, output median_code,
                    output frame_index, output frame_last, input ready);
    modport sink   (input valid, input distance_mm, input median_code,
                    input frame_index, input frame_last, output ready);
endinterface

// ----- rtl/core/median3_ir_distance_framer_top.sv -----
// Median-of-three IR distance framer, top level.
// A sample word passes accept, set-up, 20 divider steps and hand-off, which
// waits for a free output word; the far distance skips the bit-serial divider.
// No new sample word is taken until the last result is handed off. Rearm words
// and samples of a full frame are taken in idle. Synchronous active-low reset
// restores config defaults, clears history, frame count and output valid.
module median3_ir_distance_framer_top import m3ir_pkg::*; #(
    parameter int unsigned FRAME_LEN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    m3ir_in_if.sink              i_in,
    m3ir_out_if.source           o_out
);

    t_cmd               cmd;
    t_status            status;
    t_state             state;
    logic               in_ready;
    logic [COUNT_W-1:0] frame_count;

    // Controller only sequences; all values live in the datapath.
    m3ir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    // Datapath holds the output word, so a new word is taken while the
    // previous result still waits downstream.
    m3ir_dp #(
        .FRAME_LEN (FRAME_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_adc_code    (i_in.adc_code),
        .i_cmd         (cmd),
        .i_out_ready   (o_out.ready),
        .o_status      (status),
        .o_frame_count (frame_count),
        .o_out_valid   (o_out.valid),
        .o_distance_mm (o_out.distance_mm),
        .o_median_code (o_out.median_code),
        .o_frame_index (o_out.frame_index),
        .o_frame_last  (o_out.frame_last)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    // frame count never runs past the frame length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_count <= COUNT_W'(FRAME_LEN))
        else $error("frame count beyond frame length");

    // last-of-frame flag only on the final position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_last) |-> (o_out.frame_index == IDX_W'(FRAME_LEN - 1)))
        else $error("frame_last on wrong index");

    // an accepted sample of an open frame starts the divider set-up
    a_start_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready && !i_in.req_type && !status.frame_full)
        |=> (state == ST_PREP))
        else $error("sample accepted without set-up");

    // a result word is loaded only from the hand-off state
    a_load_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !$past(o_out.valid)) |-> ($past(state) == ST_DONE))
        else $error("result loaded outside hand-off");
`endif

endmodule

// ----- rtl/core/m3ir_dp.sv -----
// Datapath: config registers, sample history, frame count, restoring divider
// and output word. Depends on m3ir_pkg.
module m3ir_dp import m3ir_pkg::*; #(
    parameter int unsigned FRAME_LEN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [CODE_W-1:0]    i_adc_code,
    input  t_cmd                 i_cmd,
    input  logic                 i_out_ready,
    output t_status              o_status,
    output logic [COUNT_W-1:0]   o_frame_count,
    output logic                 o_out_valid,
    output logic [DIST_W-1:0]    o_distance_mm,
    output logic [CODE_W-1:0]    o_median_code,
    output logic [IDX_W-1:0]     o_frame_index,
    output logic                 o_frame_last
);

    localparam logic [COUNT_W-1:0] LEN = COUNT_W'(FRAME_LEN);

    logic [CODE_W-1:0]  r_near, r_offset, r_far;
    logic [DIST_W-1:0]  r_scale;
    logic [CODE_W-1:0]  r_newest, r_middle, r_oldest;
    logic [COUNT_W-1:0] r_count;
    logic [CODE_W-1:0]  r_med;
    logic [IDX_W-1:0]   r_pos;
    logic [CODE_W-1:0]  r_div;
    logic [CODE_W-1:0]  r_rem;
    logic [DIST_W-1:0]  r_quo;
    logic               r_out_valid;
    logic [DIST_W-1:0]  r_out_dist;
    logic [CODE_W-1:0]  r_out_med;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;

    logic [CODE_W:0]    rem_shift;
    logic [CODE_W+1:0]  diff;
    logic               fits;
    logic               last_pos;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= NEAR_RST;
            r_scale  <= SCALE_RST;
            r_offset <= OFFSET_RST;
            r_far    <= FAR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NEAR:   r_near   <= i_cfg_data[CODE_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data[DIST_W-1:0];
                CFG_OFFSET: r_offset <= i_cfg_data[CODE_W-1:0];
                CFG_FAR:    r_far    <= i_cfg_data[CODE_W-1:0];
                default:    ;
            endcase
        end
    end

    // history and frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_middle <= '0;
            r_oldest <= '0;
            r_count  <= '0;
        end else begin
            if (i_cmd.shift) begin
                r_newest <= i_adc_code;
                r_middle <= r_newest;
                r_oldest <= r_middle;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.start) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // restoring division step: remainder stays below the divisor
    assign rem_shift = {r_rem, r_quo[DIST_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, r_div};
    assign fits      = ~diff[CODE_W+1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_med <= mid_of_three(i_adc_code, r_newest, r_middle);
            r_pos <= r_count[IDX_W-1:0];
        end
        if (i_cmd.prep) begin
            r_rem <= '0;
            r_div <= r_med - r_offset;
            r_quo <= o_status.far_sel ? {{(DIST_W-CODE_W){1'b0}}, r_far} : r_scale;
        end else if (i_cmd.step) begin
            r_rem <= fits ? diff[CODE_W-1:0] : rem_shift[CODE_W-1:0];
            r_quo <= {r_quo[DIST_W-2:0], fits};
        end
    end

    assign last_pos = ({1'b0, r_pos} + 1'b1) == LEN;

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_dist <= r_quo;
            r_out_med  <= r_med;
            r_out_idx  <= r_pos;
            r_out_last <= last_pos;
        end
    end

    assign o_status.frame_full = (r_count >= LEN);
    assign o_status.far_sel    = (r_med < r_near) || (r_med <= r_offset);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_frame_count = r_count;
    assign o_out_valid   = r_out_valid;
    assign o_distance_mm = r_out_dist;
    assign o_median_code = r_out_med;
    assign o_frame_index = r_out_idx;
    assign o_frame_last  = r_out_last;

endmodule

// ----- rtl/core/m3ir_ctrl.sv -----
// Controller state machine: sequences accept, divider set-up, division
// steps and result hand-off. Depends on m3ir_pkg.
module m3ir_ctrl import m3ir_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_req_type,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd,
    output t_state  o_state
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (t_req'(i_req_type) == REQ_REARM) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.shift = 1'b1;
                        if (!i_status.frame_full) begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = '0;
                n_state    = i_status.far_sel ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_state = r_state;

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the median-of-three IR distance framer: directed table, then random phases.
// Self-checking against an in-bench model of filter, conversion and framing.
// Depends on m3ir_pkg, the m3ir channel interfaces and median3_ir_distance_framer_top.
`timescale 1ns / 100ps

module tb_top;
    import m3ir_pkg::*;

    localparam int unsigned FRAME_LEN       = 64;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned ITEMS_PER_PHASE = 60;
    localparam int unsigned IDLE_GUARD      = 32;    // longer than the sample-to-result latency
    localparam int unsigned HOLD_CYCLES     = 400;   // long receiver hold-off
    localparam int unsigned WATCHDOG_LIMIT  = 4000;  // cycles with nothing moving
    localparam int unsigned MAX_REPORTS     = 10;

    // One result word as it leaves the block.
    typedef struct packed {
        logic [DIST_W-1:0] distance_mm;
        logic [CODE_W-1:0] median_code;
        logic [IDX_W-1:0]  frame_index;
        logic              frame_last;
    } t_dist_word;

    localparam t_dist_word NO_WORD = '0;

    // Directed table rows: an input word, or a register write between words.
    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_REARM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    sel;      // register, for ROW_CFG
        logic [19:0] val;      // register value, or ADC code in the low 12 bits
        logic        chk;      // expected word typed in below
        t_dist_word  want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    m3ir_in_if  in_ch ();
    m3ir_out_if out_ch ();

    median3_ir_distance_framer_top #(
        .FRAME_LEN (FRAME_LEN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Model state: register copies start at their reset values,
    // history and frame count at zero.
    // ---------------------------------------------------------------
    logic [CODE_W-1:0]  lim_near  = NEAR_RST;
    logic [DIST_W-1:0]  num_scale = SCALE_RST;
    logic [CODE_W-1:0]  off_code  = OFFSET_RST;
    logic [CODE_W-1:0]  far_mm    = FAR_RST;
    logic [CODE_W-1:0]  hist_new  = '0;
    logic [CODE_W-1:0]  hist_mid  = '0;
    logic [CODE_W-1:0]  hist_old  = '0;
    logic [COUNT_W-1:0] frame_cnt = '0;

    t_dist_word  pending_dist [$];   // expected words, oldest first
    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;

    // Typed-in expectation travelling with the word on offer.
    bit          cur_chk = 1'b0;
    t_dist_word  cur_exp = '0;

    // Receiver pacing.
    bit          no_idle    = 1'b0;
    bit          hold_req   = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;

    // Median as the larger of min(a,b) and min(max(a,b),c).
    function automatic logic [CODE_W-1:0] median_of3(
        input logic [CODE_W-1:0] a,
        input logic [CODE_W-1:0] b,
        input logic [CODE_W-1:0] c
    );
        logic [CODE_W-1:0] lo;
        logic [CODE_W-1:0] hi;
        logic [CODE_W-1:0] cap;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        cap = (c < hi) ? c : hi;
        return (cap > lo) ? cap : lo;
    endfunction

    // Below the near limit, or a divisor of zero or less: far distance.
    function automatic logic [DIST_W-1:0] code_to_mm(input logic [CODE_W-1:0] med);
        logic [DIST_W-1:0] divisor;
        if (med < lim_near || med <= off_code) begin
            return DIST_W'(far_mm);
        end
        divisor = DIST_W'(med) - DIST_W'(off_code);
        return num_scale / divisor;
    endfunction

    // Advance the model by one accepted word; gives = a result word is due.
    task automatic filter_and_convert(
        input  t_req              req,
        input  logic [CODE_W-1:0] code,
        output bit                gives,
        output t_dist_word        res
    );
        logic [CODE_W-1:0] med;
        gives = 1'b0;
        res   = NO_WORD;
        if (req == REQ_REARM) begin
            // history untouched, frame restarts
            frame_cnt = '0;
        end else begin
            hist_old = hist_mid;
            hist_mid = hist_new;
            hist_new = code;
            if (frame_cnt < FRAME_LEN) begin
                med             = median_of3(hist_new, hist_mid, hist_old);
                res.frame_index = frame_cnt[IDX_W-1:0];
                frame_cnt       = frame_cnt + 1'b1;
                res.frame_last  = (frame_cnt == FRAME_LEN);
                res.median_code = med;
                res.distance_mm = code_to_mm(med);
                gives           = 1'b1;
            end
        end
    endtask

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic check_field(
        input string       field,
        input logic [19:0] got,
        input logic [19:0] want,
        input int          idx
    );
        if (got !== want) begin
            note_fail($sformatf("mismatch %s (expected frame index %0d): expected %0d, got %0d",
                                field, idx, want, got));
        end
    endtask

    // ---------------------------------------------------------------
    // Scoreboard: all handshakes sampled at the rising edge.
    // Result words are checked before the model moves on, as a word
    // accepted on this edge cannot have its result on the same edge.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_dist_word got;
        t_dist_word want;
        t_dist_word pred;
        bit         gives;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.distance_mm, out_ch.median_code,
                        out_ch.frame_index, out_ch.frame_last};
                if (pending_dist.size() == 0) begin
                    note_fail($sformatf("unexpected word: dist %0d med %0d idx %0d last %0d",
                                        got.distance_mm, got.median_code,
                                        got.frame_index, got.frame_last));
                end else begin
                    want = pending_dist.pop_front();
                    check_field("distance_mm", got.distance_mm, want.distance_mm,
                                want.frame_index);
                    check_field("median_code", got.median_code, want.median_code,
                                want.frame_index);
                    check_field("frame_index", got.frame_index, want.frame_index,
                                want.frame_index);
                    check_field("frame_last", got.frame_last, want.frame_last,
                                want.frame_index);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                filter_and_convert(t_req'(in_ch.req_type), in_ch.adc_code, gives, pred);
                if (gives) begin
                    pending_dist.push_back(cur_chk ? cur_exp : pred);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NEAR:   lim_near  = i_cfg_data[CODE_W-1:0];
                    CFG_SCALE:  num_scale = i_cfg_data[DIST_W-1:0];
                    CFG_OFFSET: off_code  = i_cfg_data[CODE_W-1:0];
                    CFG_FAR:    far_mm    = i_cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: nothing accepted for too long ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle) begin
            return 0;
        end
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request,
    // counted here so that the sender keeps offering words meanwhile.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            stall_left = idle_gap();
        end
    end

    // Offer one word after a random gap, return once it is taken.
    // valid is only lowered in a gap, so it never drops and rises in one step.
    task automatic send_word(
        input t_req              req,
        input logic [CODE_W-1:0] code,
        input bit                chk,
        input t_dist_word        want
    );
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= req;
        in_ch.adc_code <= code;
        cur_chk = chk;
        cur_exp = want;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering, let every expected word arrive, then allow for a
    // trailing word that gives no result (rearm or full-frame sample).
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_dist.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    // Register write while idle; spare upper data bits of 12-bit registers toggle.
    task automatic write_reg(input t_cfg_idx sel, input logic [19:0] value);
        logic [CFG_W-1:0] data;
        data = value;
        if (sel != CFG_SCALE) begin
            data[CFG_W-1:CODE_W] = (CFG_W - CODE_W)'($urandom);
        end
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Codes bunched around the near limit, the offset, the extremes and
    // repeats of the newest sample, so medians land on the boundaries.
    function automatic logic [CODE_W-1:0] rand_code();
        int v;
        case ($urandom_range(0, 15))
            0:          v = 0;
            1:          v = 4095;
            2, 3, 4, 5: v = int'(lim_near) + int'($urandom_range(0, 4)) - 2;
            6, 7, 8:    v = int'(off_code) + int'($urandom_range(0, 3)) - 1;
            9, 10:      v = int'(hist_new);
            default:    v = int'($urandom_range(0, 4095));
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > 4095) begin
            v = 4095;
        end
        return CODE_W'(v);
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        t_row              dir_table [$];
        logic [CODE_W-1:0] c_near;
        logic [DIST_W-1:0] c_scale;
        logic [CODE_W-1:0] c_off;
        logic [CODE_W-1:0] c_far;
        bit                rearm;

        // every input known from time zero
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_NEAR;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_SAMPLE;
        in_ch.adc_code = '0;
        out_ch.ready   = 1'b0;

        // Directed words. Typed expectations follow the reset registers:
        // near 494, scale 268130, offset 159, far 799; history starts at zero.
        dir_table = '{
            // startup: zero history drags the median down
            '{ROW_SAMPLE, CFG_NEAR,   20'd0,       1'b1, '{20'd799,   12'd0,    6'd0, 1'b0}},
            '{ROW_SAMPLE, CFG_NEAR,   20'd4095,    1'b1, '{20'd799,   12'd0,    6'd1, 1'b0}},
            '{ROW_SAMPLE, CFG_NEAR,   20'd4095,    1'b1, '{20'd68,    12'd4095, 6'd2, 1'b0}},
            '{ROW_SAMPLE, CFG_NEAR,   20'd0,       1'b1, '{20'd68,    12'd4095, 6'd3, 1'b0}},
            // median exactly at, then just below, the near limit
            '{ROW_SAMPLE, CFG_NEAR,   20'd494,     1'b1, '{20'd800,   12'd494,  6'd4, 1'b0}},
            '{ROW_SAMPLE, CFG_NEAR,   20'd493,     1'b1, '{20'd799,   12'd493,  6'd5, 1'b0}},
            '{ROW_SAMPLE, CFG_NEAR,   20'd1000,    1'b1, '{20'd800,   12'd494,  6'd6, 1'b0}},
            // rearm of a part-filled frame
            '{ROW_REARM,  CFG_NEAR,   20'd0,       1'b0, NO_WORD},
            '{ROW_SAMPLE, CFG_NEAR,   20'd1000,    1'b0, NO_WORD},
            // divisor zero or less with the near limit out of the way
            '{ROW_CFG,    CFG_NEAR,   20'd0,       1'b0, NO_WORD},
            '{ROW_CFG,    CFG_OFFSET, 20'd2000,    1'b0, NO_WORD},
            '{ROW_CFG,    CFG_FAR,    20'd4095,    1'b0, NO_WORD},
            '{ROW_CFG,    CFG_SCALE,  20'hFFFFF,   1'b0, NO_WORD},
            '{ROW_SAMPLE, CFG_NEAR,   20'd2000,    1'b0, NO_WORD},
            '{ROW_SAMPLE, CFG_NEAR,   20'd2000,    1'b0, NO_WORD},
            '{ROW_SAMPLE, CFG_NEAR,   20'd2001,    1'b0, NO_WORD},
            // divisor of one: full-scale distance
            '{ROW_SAMPLE, CFG_NEAR,   20'd2001,    1'b1, '{20'hFFFFF, 12'd2001, 6'd4, 1'b0}},
            '{ROW_CFG,    CFG_SCALE,  20'd0,       1'b0, NO_WORD},
            '{ROW_SAMPLE, CFG_NEAR,   20'd4095,    1'b1, '{20'd0,     12'd2001, 6'd5, 1'b0}},
            '{ROW_CFG,    CFG_FAR,    20'd0,       1'b0, NO_WORD},
            '{ROW_CFG,    CFG_OFFSET, 20'd0,       1'b0, NO_WORD},
            '{ROW_SAMPLE, CFG_NEAR,   20'd0,       1'b0, NO_WORD},
            '{ROW_SAMPLE, CFG_NEAR,   20'd0,       1'b1, '{20'd0,     12'd0,    6'd7, 1'b0}},
            '{ROW_REARM,  CFG_NEAR,   20'd0,       1'b0, NO_WORD},
            '{ROW_SAMPLE, CFG_NEAR,   20'd4095,    1'b1, '{20'd0,     12'd0,    6'd0, 1'b0}}
        };

        // reset once, released on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            case (dir_table[i].kind)
                ROW_CFG:   write_reg(dir_table[i].sel, dir_table[i].val);
                ROW_REARM: send_word(REQ_REARM, CODE_W'($urandom), 1'b0, NO_WORD);
                default:   send_word(REQ_SAMPLE, dir_table[i].val[CODE_W-1:0],
                                     dir_table[i].chk, dir_table[i].want);
            endcase
        end

        // Random phases, each under its own register setting. Mostly long
        // runs of samples that fill the frame and run past it, then rearm;
        // now and then a rearm cuts a frame short.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    c_near = NEAR_RST; c_scale = SCALE_RST;
                    c_off  = OFFSET_RST; c_far = FAR_RST;
                end
                1: begin
                    c_near = '0; c_scale = DIST_W'($urandom);
                    c_off  = '0; c_far = CODE_W'($urandom);
                end
                3: begin
                    c_near = 12'd4095; c_scale = 20'hFFFFF;
                    c_off  = 12'd4094; c_far = 12'd4095;
                end
                4: begin
                    c_near = '0; c_scale = '0; c_off = '0; c_far = '0;
                end
                default: begin
                    c_near  = CODE_W'($urandom_range(0, 4095));
                    c_off   = CODE_W'($urandom_range(0, c_near));
                    c_scale = DIST_W'($urandom);
                    c_far   = CODE_W'($urandom);
                end
            endcase
            write_reg(CFG_NEAR, 20'(c_near));
            write_reg(CFG_SCALE, c_scale);
            write_reg(CFG_OFFSET, 20'(c_off));
            write_reg(CFG_FAR, 20'(c_far));

            no_idle = (ph == 1 || ph == 5);
            // long receiver hold-off: the block fills and stalls its input
            if (ph == 2) begin
                hold_req = 1'b1;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender pauses mid-phase until everything has drained
                if (ph == 4 && n == ITEMS_PER_PHASE / 2) begin
                    wait_idle();
                end
                if (frame_cnt >= FRAME_LEN) begin
                    rearm = ($urandom_range(0, 3) == 0);
                end else begin
                    rearm = ($urandom_range(0, 59) == 0);
                end
                if (rearm) begin
                    send_word(REQ_REARM, CODE_W'($urandom), 1'b0, NO_WORD);
                end else begin
                    send_word(REQ_SAMPLE, rand_code(), 1'b0, NO_WORD);
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_dist.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
